// File: design/ild_pkg.sv
// Shared types and constants for the x86 instruction length decoder.
package ild_pkg;

  // Longest legal instruction in bytes.
  localparam int unsigned MAX_INSN_LEN = 15;

  // Entries in the queue between the classifier and the length sequencer.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Table lookups done on every code byte before it is queued.
  typedef struct packed {
    logic       is_prefix;  // legacy prefix
    logic       is_rex;     // REX byte 40..4F
    logic       is_esc;     // 0F escape
    logic       modrm1;     // one-byte opcode takes a ModRM byte
    logic       modrm2;     // two-byte opcode takes a ModRM byte
    logic       movabs;     // B8..BF, immediate widens with REX.W
    logic [2:0] imm1;       // one-byte opcode immediate size
    logic [2:0] grp3;       // extra immediate when ModRM.reg is zero
    logic [2:0] imm2;       // two-byte opcode immediate size
  } byte_class_t;

  // One queued code byte.
  typedef struct packed {
    logic [7:0]  code_byte;
    logic        region_last;
    byte_class_t cls;
  } q_entry_t;

endpackage

// File: design/ild_front.sv
// Front end: accepts code bytes and classifies them with the opcode tables.
module ild_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_code_byte,
  input  logic            in_region_last,
  input  logic            q_ready,
  output logic            q_push,
  output ild_pkg::q_entry_t q_entry
);
  import ild_pkg::*;

  function automatic logic f_prefix(input logic [7:0] b);
    return b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
           b == 8'h65;
  endfunction

  function automatic logic f_modrm1(input logic [7:0] op);
    return (op < 8'h40 && !op[2]) || op == 8'h62 || op == 8'h63 || op == 8'h69 ||
           op == 8'h6B || (op >= 8'h80 && op <= 8'h8F) || op == 8'hC0 ||
           op == 8'hC1 || (op >= 8'hC4 && op <= 8'hC7) ||
           (op >= 8'hD0 && op <= 8'hD3) || op == 8'hF6 || op == 8'hF7 || op >= 8'hFE;
  endfunction

  function automatic logic f_modrm2(input logic [7:0] op);
    return (op >= 8'h10 && op <= 8'h1F) || (op >= 8'h28 && op <= 8'h2F) ||
           (op >= 8'h40 && op <= 8'h4F) || (op >= 8'h90 && op <= 8'h9F) ||
           (op >= 8'hA3 && op <= 8'hA5) || (op >= 8'hAB && op <= 8'hAF) ||
           (op >= 8'hB0 && op <= 8'hB7) || (op >= 8'hBA && op <= 8'hBF);
  endfunction

  // Immediate size of a one-byte opcode without REX.W and for a nonzero reg field.
  function automatic logic [2:0] f_imm1(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    if ((op >= 8'h70 && op <= 8'h7F) || op == 8'hEB) n = 3'd1;
    else if (op == 8'hE8 || op == 8'hE9 || (op >= 8'hA0 && op <= 8'hA3)) n = 3'd4;
    else if (op == 8'hC2 || op == 8'hCA) n = 3'd2;
    else if (op == 8'hC8) n = 3'd3;
    else if (op == 8'hCD || op == 8'h6A) n = 3'd1;
    else if (op == 8'h68) n = 3'd4;
    else if (op >= 8'hB8 && op <= 8'hBF) n = 3'd4;
    else if (op == 8'hC6) n = 3'd1;
    else if (op == 8'hC7) n = 3'd4;
    else if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC0 ||
             op == 8'hC1 || op == 8'h6B) n = 3'd1;
    else if (op == 8'h81 || op == 8'h69) n = 3'd4;
    return n;
  endfunction

  function automatic logic [2:0] f_grp3(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    if (op == 8'hF6) n = 3'd1;
    else if (op == 8'hF7) n = 3'd4;
    return n;
  endfunction

  function automatic logic [2:0] f_imm2(input logic [7:0] op);
    logic [2:0] n;
    n = 3'd0;
    if (op >= 8'h80 && op <= 8'h8F) n = 3'd4;
    else if (op == 8'hBA) n = 3'd1;
    return n;
  endfunction

  // A request is taken whenever the queue has room.
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Classify the byte for every role it may play in the sequencer.
  always_comb begin
    q_entry.code_byte     = in_code_byte;
    q_entry.region_last   = in_region_last;
    q_entry.cls.is_prefix = f_prefix(in_code_byte);
    q_entry.cls.is_rex    = (in_code_byte[7:4] == 4'h4);
    q_entry.cls.is_esc    = (in_code_byte == 8'h0F);
    q_entry.cls.modrm1    = f_modrm1(in_code_byte);
    q_entry.cls.modrm2    = f_modrm2(in_code_byte);
    q_entry.cls.movabs    = (in_code_byte >= 8'hB8 && in_code_byte <= 8'hBF);
    q_entry.cls.imm1      = f_imm1(in_code_byte);
    q_entry.cls.grp3      = f_grp3(in_code_byte);
    q_entry.cls.imm2      = f_imm2(in_code_byte);
  end

endmodule

// File: design/ild_queue.sv
// Short queue of classified code bytes between the front end and the sequencer.
module ild_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ild_pkg::q_entry_t push_entry,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output ild_pkg::q_entry_t pop_entry
);
  import ild_pkg::*;

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: design/ild_back.sv
// Back end: length sequencer that walks prefixes, opcode, ModRM, SIB and trailing bytes.
module ild_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ild_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_insn_length,
  output logic              out_status
);
  import ild_pkg::*;

  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_MODRM   = 3'd2;
  localparam logic [2:0] PH_SIB     = 3'd3;
  localparam logic [2:0] PH_TAIL    = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  logic [2:0] phase_r, phase_nxt;
  logic [3:0] count_r, count_nxt;
  logic       wide_r, wide_nxt;
  logic [3:0] imm_r, imm_nxt;
  logic [2:0] grp_r, grp_nxt;
  logic [1:0] mod_r, mod_nxt;
  logic [2:0] reg_r, reg_nxt;
  logic [3:0] left_r, left_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] len_r, len_nxt;
  logic       status_r, status_nxt;

  logic [7:0] b;
  logic [4:0] cnt;
  logic       done, emit;

  assign b     = q_entry.code_byte;
  assign cnt   = {1'b0, count_r} + 5'd1;
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_insn_length = len_r;
  assign out_status      = status_r;

  // Per-byte sequencer step.
  always_comb begin
    logic       needs_modrm;
    logic       tail_go;
    logic [3:0] imm_sel;
    logic [2:0] grp_sel;
    logic [2:0] disp;
    logic [4:0] tail_n;
    logic [3:0] left_dec;

    phase_nxt   = phase_r;
    count_nxt   = count_r;
    wide_nxt    = wide_r;
    imm_nxt     = imm_r;
    grp_nxt     = grp_r;
    mod_nxt     = mod_r;
    reg_nxt     = reg_r;
    left_nxt    = left_r;
    done        = 1'b0;
    emit        = 1'b0;
    len_nxt     = len_r;
    status_nxt  = status_r;
    needs_modrm = 1'b0;
    tail_go     = 1'b0;
    imm_sel     = 4'd0;
    grp_sel     = 3'd0;
    disp        = 3'd0;
    tail_n      = 5'd0;
    left_dec    = 4'd0;

    // Opcode lookups, used in the prefix phase and after the escape byte.
    if (phase_r == PH_ESC) begin
      needs_modrm = q_entry.cls.modrm2;
      imm_sel     = {1'b0, q_entry.cls.imm2};
      grp_sel     = 3'd0;
    end else begin
      needs_modrm = q_entry.cls.modrm1;
      imm_sel     = (q_entry.cls.movabs && wide_r) ? 4'd8 : {1'b0, q_entry.cls.imm1};
      grp_sel     = q_entry.cls.grp3;
    end

    case (phase_r)
      PH_DISCARD: begin
        // Bytes after an error are dropped up to the end of the region.
      end
      PH_ESC: begin
        imm_nxt = imm_sel;
        grp_nxt = grp_sel;
        if (needs_modrm) begin
          phase_nxt = PH_MODRM;
        end else begin
          tail_n  = {1'b0, imm_sel};
          tail_go = 1'b1;
        end
      end
      PH_MODRM: begin
        mod_nxt = b[7:6];
        reg_nxt = b[5:3];
        if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
          phase_nxt = PH_SIB;
        end else begin
          if (b[7:6] == 2'd0 && b[2:0] == 3'd5) disp = 3'd4;
          else if (b[7:6] == 2'd1) disp = 3'd1;
          else if (b[7:6] == 2'd2) disp = 3'd4;
          tail_n  = {2'b0, disp} + {1'b0, imm_r} +
                    ((b[5:3] == 3'd0) ? {2'b0, grp_r} : 5'd0);
          tail_go = 1'b1;
        end
      end
      PH_SIB: begin
        if (mod_r == 2'd0 && b[2:0] == 3'd5) disp = 3'd4;
        else if (mod_r == 2'd1) disp = 3'd1;
        else if (mod_r == 2'd2) disp = 3'd4;
        tail_n  = {2'b0, disp} + {1'b0, imm_r} +
                  ((reg_r == 3'd0) ? {2'b0, grp_r} : 5'd0);
        tail_go = 1'b1;
      end
      PH_TAIL: begin
        left_dec = (left_r != 4'd0) ? left_r - 4'd1 : left_r;
        left_nxt = left_dec;
        done     = (left_dec == 4'd0);
      end
      default: begin
        if (q_entry.cls.is_prefix) begin
          phase_nxt = PH_PREFIX;
        end else if (q_entry.cls.is_rex) begin
          wide_nxt  = b[3];
          phase_nxt = PH_PREFIX;
        end else if (q_entry.cls.is_esc) begin
          phase_nxt = PH_ESC;
        end else begin
          imm_nxt = imm_sel;
          grp_nxt = grp_sel;
          if (needs_modrm) begin
            phase_nxt = PH_MODRM;
          end else begin
            tail_n  = {1'b0, imm_sel};
            tail_go = 1'b1;
          end
        end
      end
    endcase

    // Entering the trailing-byte phase, or finishing when nothing remains.
    if (tail_go) begin
      if (tail_n == 5'd0) begin
        done = 1'b1;
      end else begin
        left_nxt  = tail_n[3:0];
        phase_nxt = PH_TAIL;
      end
    end

    // Error, completion, or keep counting.
    if (phase_r == PH_DISCARD) begin
      if (q_entry.region_last) begin
        phase_nxt = PH_PREFIX;
        count_nxt = 4'd0;
        wide_nxt  = 1'b0;
        imm_nxt   = 4'd0;
        grp_nxt   = 3'd0;
        mod_nxt   = 2'd0;
        reg_nxt   = 3'd0;
        left_nxt  = 4'd0;
      end
    end else if (cnt > 5'(MAX_INSN_LEN) || (!done && q_entry.region_last)) begin
      emit       = 1'b1;
      len_nxt    = 4'd0;
      status_nxt = STATUS_ERR;
      phase_nxt  = q_entry.region_last ? PH_PREFIX : PH_DISCARD;
      count_nxt  = 4'd0;
      wide_nxt   = 1'b0;
      imm_nxt    = 4'd0;
      grp_nxt    = 3'd0;
      mod_nxt    = 2'd0;
      reg_nxt    = 3'd0;
      left_nxt   = 4'd0;
    end else if (done) begin
      emit       = 1'b1;
      len_nxt    = cnt[3:0];
      status_nxt = STATUS_OK;
      phase_nxt  = PH_PREFIX;
      count_nxt  = 4'd0;
      wide_nxt   = 1'b0;
      imm_nxt    = 4'd0;
      grp_nxt    = 3'd0;
      mod_nxt    = 2'd0;
      reg_nxt    = 3'd0;
      left_nxt   = 4'd0;
    end else begin
      count_nxt = cnt[3:0];
    end
  end

  // Output register: load on a new result, clear once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PREFIX;
      count_r     <= '0;
      wide_r      <= 1'b0;
      imm_r       <= '0;
      grp_r       <= '0;
      mod_r       <= '0;
      reg_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        wide_r  <= wide_nxt;
        imm_r   <= imm_nxt;
        grp_r   <= grp_nxt;
        mod_r   <= mod_nxt;
        reg_r   <= reg_nxt;
        left_r  <= left_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      len_r    <= len_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// File: design/x86_instruction_length_decoder.sv
// Top level of the x86-64 instruction length decoder.
// The decoder takes one code byte per clock cycle when the input is not stalled and reports
// the length of each instruction once the sequencer has consumed its last byte: an accepted
// byte is classified and written into a two-entry queue, the sequencer consumes it from the
// queue head, and any result it causes is loaded into an output register and held there until
// it is taken. The sustained rate is one byte per cycle, as the length sequencer takes a byte
// each step unless held; while a result waits to be taken the sequencer holds, and the queue
// still takes up to two more bytes before the input stalls.
// An error result (length 0, status 1) is given for instructions past 15 bytes and for
// regions that end mid-instruction; bytes are then dropped up to the region's last byte.
module x86_instruction_length_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_code_byte,
  input  logic       in_region_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_insn_length,
  output logic       out_status
);
  import ild_pkg::*;

  logic     q_ready, q_push, q_valid, q_pop;
  q_entry_t q_in_entry, q_out_entry;

  // Classify incoming bytes.
  ild_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_byte   (in_code_byte),
    .in_region_last (in_region_last),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_entry        (q_in_entry)
  );

  // Decouple the front end from the sequencer.
  ild_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out_entry)
  );

  // Walk the instruction and produce lengths.
  ild_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_out_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_insn_length (out_insn_length),
    .out_status      (out_status)
  );

endmodule

// File: sim/ild_length_board_pkg.sv
// Length predictor and result scoreboard for the instruction length decoder bench.
package ild_length_board_pkg;

  import ild_pkg::MAX_INSN_LEN;

  // Decoder phases, one per kind of byte the next code byte is taken to be.
  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_ESC     = 3'd1,
    PH_MODRM   = 3'd2,
    PH_SIB     = 3'd3,
    PH_TAIL    = 3'd4,
    PH_DISCARD = 3'd5
  } decode_phase_t;

  typedef struct packed {
    decode_phase_t phase;
    logic [4:0]    count;
    logic          wide;
    logic          esc;
    logic [7:0]    opcode;
    logic [7:0]    modrm;
    logic [3:0]    left;
  } decode_state_t;

  typedef struct packed {
    logic [3:0] insn_length;
    logic       status;
  } length_result_t;

  function automatic bit is_legacy_prefix(logic [7:0] b);
    return b == 8'h66 || b == 8'h67 || b == 8'hF0 || b == 8'hF2 || b == 8'hF3 ||
           b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
           b == 8'h65;
  endfunction

  function automatic bit takes_modrm_1b(logic [7:0] op);
    return (op < 8'h40 && !op[2]) || op == 8'h62 || op == 8'h63 || op == 8'h69 ||
           op == 8'h6B || op[7:4] == 4'h8 || op == 8'hC0 || op == 8'hC1 ||
           (op >= 8'hC4 && op <= 8'hC7) || (op >= 8'hD0 && op <= 8'hD3) ||
           op == 8'hF6 || op == 8'hF7 || op >= 8'hFE;
  endfunction

  function automatic bit takes_modrm_2b(logic [7:0] op);
    return op[7:4] == 4'h1 || op[7:3] == 5'h05 || op[7:4] == 4'h4 || op[7:4] == 4'h9 ||
           (op >= 8'hA3 && op <= 8'hA5) || (op >= 8'hAB && op <= 8'hAF) ||
           (op >= 8'hB0 && op <= 8'hB7) || op >= 8'hBA && op <= 8'hBF;
  endfunction

  // Immediate bytes of a one-byte opcode; reg is the ModRM reg field.
  function automatic int unsigned imm_size_1b(logic [7:0] op, logic w, logic [2:0] reg_f);
    if ((op >= 8'h70 && op <= 8'h7F) || op == 8'hEB) return 1;
    if (op == 8'hE8 || op == 8'hE9 || (op >= 8'hA0 && op <= 8'hA3)) return 4;
    if (op == 8'hC2 || op == 8'hCA) return 2;
    if (op == 8'hC8) return 3;
    if (op == 8'hCD || op == 8'h6A) return 1;
    if (op == 8'h68) return 4;
    if (op >= 8'hB8 && op <= 8'hBF) return w ? 8 : 4;
    if (op == 8'hC6) return 1;
    if (op == 8'hC7) return 4;
    if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC0 || op == 8'hC1 ||
        op == 8'h6B) return 1;
    if (op == 8'h81 || op == 8'h69) return 4;
    if (op == 8'hF6 && reg_f == 3'd0) return 1;
    if (op == 8'hF7 && reg_f == 3'd0) return 4;
    return 0;
  endfunction

  function automatic int unsigned imm_size_2b(logic [7:0] op);
    if (op[7:4] == 4'h8) return 4;
    if (op == 8'hBA) return 1;
    return 0;
  endfunction

  // Displacement bytes from the mod field and the rm (or SIB base) field.
  function automatic int unsigned disp_size(logic [1:0] mod, logic [2:0] low);
    if (mod == 2'd0 && low == 3'd5) return 4;
    if (mod == 2'd1) return 1;
    if (mod == 2'd2) return 4;
    return 0;
  endfunction

  class insn_length_board;
    decode_state_t  st;
    length_result_t expected_q[$];
    int unsigned    requests;
    int unsigned    results;
    int unsigned    error_results;
    int unsigned    errors;

    function new();
      clear_insn(PH_PREFIX);
      requests      = 0;
      results       = 0;
      error_results = 0;
      errors        = 0;
    endfunction

    function void clear_insn(decode_phase_t next_phase);
      st.phase  = next_phase;
      st.count  = '0;
      st.wide   = 1'b0;
      st.esc    = 1'b0;
      st.opcode = '0;
      st.modrm  = '0;
      st.left   = '0;
    endfunction

    function int unsigned imm_for(logic [2:0] reg_f);
      return st.esc ? imm_size_2b(st.opcode) : imm_size_1b(st.opcode, st.wide, reg_f);
    endfunction

    // Moves to the trailing bytes; returns 1 when none remain.
    function bit set_tail(int unsigned n);
      if (n == 0) return 1'b1;
      st.left  = n[3:0];
      st.phase = PH_TAIL;
      return 1'b0;
    endfunction

    function bit after_opcode();
      if (st.esc ? takes_modrm_2b(st.opcode) : takes_modrm_1b(st.opcode)) begin
        st.phase = PH_MODRM;
        return 1'b0;
      end
      return set_tail(imm_for(3'd0));
    endfunction

    // Advances the decode state by one code byte; returns 1 when a result is due.
    function bit step(input logic [7:0] b, input logic last,
                      output logic [3:0] len, output logic status);
      logic [4:0] cnt;
      bit         done;
      len    = '0;
      status = 1'b0;
      done   = 1'b0;
      if (st.phase == PH_DISCARD) begin
        if (last) clear_insn(PH_PREFIX);
        return 1'b0;
      end
      cnt = st.count + 5'd1;
      case (st.phase)
        PH_ESC: begin
          st.opcode = b;
          done = after_opcode();
        end
        PH_MODRM: begin
          st.modrm = b;
          if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
            st.phase = PH_SIB;
          end else begin
            done = set_tail(disp_size(b[7:6], b[2:0]) + imm_for(b[5:3]));
          end
        end
        PH_SIB: begin
          done = set_tail(disp_size(st.modrm[7:6], b[2:0]) + imm_for(st.modrm[5:3]));
        end
        PH_TAIL: begin
          if (st.left > 0) st.left = st.left - 4'd1;
          done = (st.left == 0);
        end
        default: begin
          if (is_legacy_prefix(b)) begin
            st.phase = PH_PREFIX;
          end else if (b[7:4] == 4'h4) begin
            st.wide  = b[3];
            st.phase = PH_PREFIX;
          end else if (b == 8'h0F) begin
            st.esc   = 1'b1;
            st.phase = PH_ESC;
          end else begin
            st.opcode = b;
            st.esc    = 1'b0;
            done = after_opcode();
          end
        end
      endcase
      // Too long, or the region ran out before the instruction finished.
      if (cnt > MAX_INSN_LEN || (!done && last)) begin
        status = 1'b1;
        clear_insn(last ? PH_PREFIX : PH_DISCARD);
        return 1'b1;
      end
      if (done) begin
        len = cnt[3:0];
        clear_insn(PH_PREFIX);
        return 1'b1;
      end
      st.count = cnt;
      return 1'b0;
    endfunction

    // Tells whether a byte would close the current instruction, state untouched.
    function bit completes(logic [7:0] b);
      decode_state_t saved;
      logic [3:0]    l;
      logic          s;
      bit            r;
      saved = st;
      r     = step(b, 1'b0, l, s);
      st    = saved;
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic last);
      length_result_t want;
      requests++;
      if (step(b, last, want.insn_length, want.status)) expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [3:0] len, logic status);
      length_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("length %0d status %0d with no instruction pending", len, status));
        return;
      end
      want = expected_q.pop_front();
      if (want.status) error_results++;
      if (len !== want.insn_length)
        report($sformatf("result %0d: length %0d, expected %0d", results, len,
                         want.insn_length));
      if (status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d", results, status,
                         want.status));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
// Top-level bench for the instruction length decoder: stimulus, pacing and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ild_length_board_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned PHASE_BYTES  = 410;

  localparam logic [7:0] LEGACY_PREFIXES [11] = '{
    8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65
  };
  localparam logic [7:0] OPS_1B [30] = '{
    8'h00, 8'h03, 8'h62, 8'h69, 8'h6B, 8'h80, 8'h81, 8'h83, 8'hC0, 8'hC6,
    8'hC7, 8'hF6, 8'hF7, 8'hFF, 8'hB8, 8'hBF, 8'hE8, 8'hEB, 8'h74, 8'hC2,
    8'hC8, 8'hCD, 8'h6A, 8'h68, 8'hA1, 8'h90, 8'hC3, 8'hD1, 8'h8B, 8'hCA
  };
  localparam logic [7:0] OPS_2B [12] = '{
    8'h80, 8'h8F, 8'h84, 8'hBA, 8'h10, 8'h1F, 8'hAF, 8'hB6, 8'h40, 8'h4F, 8'h05, 8'hA2
  };

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_code_byte   = 8'h00;
  logic       in_region_last = 1'b0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [3:0] out_insn_length;
  logic       out_status;

  insn_length_board sb     = new();
  insn_length_board shaper = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned sent           = 0;

  x86_instruction_length_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_byte    (in_code_byte),
    .in_region_last  (in_region_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_insn_length (out_insn_length),
    .out_status      (out_status)
  );

  // Free-running 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver pacing, with a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Accepted requests feed the predictor; accepted results are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_code_byte, in_region_last);
      if (out_valid && out_ready) sb.check_result(out_insn_length, out_status);
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offers one code byte and returns at the falling edge after it is taken.
  task automatic send_code_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_code_byte   <= b;
    in_region_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a byte and tracks the stream shape so that the next byte can be chosen.
  task automatic emit(input logic [7:0] b, input logic last, output bit closes);
    logic [3:0] l;
    logic       s;
    closes = shaper.step(b, last, l, s);
    send_code_byte(b, last);
    sent++;
  endtask

  // Picks a byte that fits where the stream currently stands.
  function automatic logic [7:0] pick_code_byte(bit want_prefix);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    case (shaper.st.phase)
      PH_ESC: begin
        if ($urandom_range(1) == 0) b = OPS_2B[$urandom_range(11)];
      end
      PH_MODRM: begin
        case ($urandom_range(3))
          0: b[2:0] = 3'd4;
          1: begin
            b[7:6] = 2'd0;
            b[2:0] = 3'd5;
          end
          default: ;
        endcase
        if ($urandom_range(3) == 0) b[5:3] = 3'd0;
      end
      PH_SIB, PH_TAIL, PH_DISCARD: ;
      default: begin
        if (want_prefix) begin
          if ($urandom_range(1) == 0) b = LEGACY_PREFIXES[$urandom_range(10)];
          else b = 8'h40 | 8'($urandom_range(15));
        end else if ($urandom_range(3) == 0) begin
          b = 8'h0F;
        end else if ($urandom_range(1) == 0) begin
          b = OPS_1B[$urandom_range(29)];
        end
      end
    endcase
    return b;
  endfunction

  // Finishes a region that an error left in discard.
  task automatic flush_region();
    bit c;
    while (shaper.st.phase == PH_DISCARD)
      emit(8'($urandom_range(255)), ($urandom_range(3) == 0), c);
  endtask

  // One instruction with random content, sometimes cut short or given too many prefixes.
  task automatic send_insn();
    int         npre;
    int         trunc_at;
    int         idx;
    bit         end_region;
    bit         got;
    logic [7:0] b;
    logic       last;
    flush_region();
    npre       = ($urandom_range(14) == 0) ? $urandom_range(16, 11) : $urandom_range(2);
    end_region = ($urandom_range(5) == 0);
    trunc_at   = ($urandom_range(11) == 0) ? $urandom_range(5) : -1;
    idx        = 0;
    got        = 1'b0;
    while (!got) begin
      b    = pick_code_byte(idx < npre);
      last = (idx == trunc_at) || (end_region && shaper.completes(b));
      emit(b, last, got);
      idx++;
    end
    flush_region();
  endtask

  // Stops offering and waits until every expected length has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [8:0]  directed [28];
    bit          c;
    int unsigned goal;
    int unsigned n;
    // Sixteen bytes with the flag on the last: too long, then restart next byte.
    directed = '{
      9'h066, 9'h0F2, 9'h0F3, 9'h0F0, 9'h02E, 9'h036, 9'h03E, 9'h026,
      9'h064, 9'h065, 9'h067, 9'h066, 9'h066, 9'h066, 9'h066, 9'h190,
      // A region of prefixes only, then an opcode cut before its ModRM.
      9'h1F0, 9'h1FF,
      // Two-byte BA with an 8-bit immediate, then F7 /0 with a 32-bit immediate.
      9'h00F, 9'h0BA, 9'h0E0, 9'h005,
      9'h0F7, 9'h0C0, 9'h000, 9'h0FF, 9'h000, 9'h0FF
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) emit(directed[i][7:0], directed[i][8], c);
    drain();

    // Four pacing phases; the first opens with a long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req++;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      goal = sent + PHASE_BYTES;
      while (sent < goal) begin
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(4, 1);
          repeat (n) emit(8'($urandom_range(255)), ($urandom_range(3) == 0), c);
        end else begin
          send_insn();
        end
      end
      drain();
    end

    $display("covered %0d code bytes over directed cases and four pacing phases",
             sb.requests);
    $display("%0d lengths checked, %0d of them error results", sb.results,
             sb.error_results);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
